// ===== rtl/rgbhsv_pkg.sv =====
// Shared types, constants and sector codes for the RGB to HSV converter.
// No dependencies; every other file in rtl/ imports this package.
package rgbhsv_pkg;

  localparam int CompBits         = 8;
  localparam int HueBits          = 16;
  // 6 * (2^CompBits - 1) fits in CompBits + 3 bits
  localparam int HueDivW          = CompBits + 3;
  localparam int HueStepsPerStage = 2;
  localparam int HueStages        = (HueBits + HueStepsPerStage - 1) / HueStepsPerStage;
  localparam int NumDivStages     = (HueStages > CompBits) ? HueStages : CompBits;
  localparam int FrontStages      = 3;
  // request edge to strobe: front stages, divider stages, output register
  localparam int Latency          = FrontStages + NumDivStages + 1;

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [CompBits-1:0] red_in;
    logic [CompBits-1:0] green_in;
    logic [CompBits-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HueBits-1:0]  hue_out;
    logic [CompBits-1:0] sat_out;
    logic [CompBits-1:0] val_out;
  } hsv_t;

  // State of one pixel inside the divider pipeline
  typedef struct packed {
    logic                gray;
    logic [CompBits-1:0] val;
    logic [HueDivW-1:0]  hrem;
    logic [HueDivW-1:0]  hdiv;
    logic [HueBits-1:0]  hq;
    logic [CompBits-1:0] srem;
    logic [CompBits-1:0] slo;
    logic [CompBits-1:0] sq;
  } div_stage_t;

endpackage

// ===== rtl/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter: front end, divider pipeline and
// output register. Depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_div.
//
// Usage
//   Request channel: drive pixel_i and raise start for one cycle per pixel.
//   A request is taken at each rising edge with start high and busy low.
//   busy is held low: the pipeline has no feedback and takes one pixel in
//   every clock, back to back, with no gaps needed between requests.
//   Result channel: done_o is high for exactly one cycle while result_o
//   holds hue, saturation and value of one pixel; results come out in
//   request order. The receiver has no way to hold results off, and none
//   is needed: no stage ever stalls.
//   Path: 3 front-end stages, 8 divider stages and 1 output register.
//   The eight divider stages come from the 16-bit hue quotient at two
//   bits a stage; the 8-bit saturation quotient runs alongside at one
//   bit a stage.
//   Throughput: one pixel per clock.
//   Reset: rst_ni clears every valid bit at once; pixels in flight are
//   dropped and done_o stays low until a new request has passed through.
//   Gray pixels (all components equal) give hue and saturation of zero.
module rgb_to_hsv_converter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  rgbhsv_pkg::pixel_t  pixel_i,
  output logic                busy,
  output logic                done_o,
  output rgbhsv_pkg::hsv_t    result_o
);
  import rgbhsv_pkg::*;

  logic        front_vld, div_vld;
  div_stage_t  front_stg, div_stg;
  logic        done_q;
  hsv_t        result_q, result_d;

  // never stalls: every stage moves on every clock
  assign busy = 1'b0;

  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .pixel_i (pixel_i),
    .valid_o (front_vld),
    .stage_o (front_stg)
  );

  rgbhsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_vld),
    .stage_i (front_stg),
    .valid_o (div_vld),
    .stage_o (div_stg)
  );

  // Gray pixels ran the hue divider against a zero divisor: force zero here
  always_comb begin
    result_d.hue_out = div_stg.gray ? '0 : div_stg.hq;
    result_d.sat_out = div_stg.gray ? '0 : div_stg.sq;
    result_d.val_out = div_stg.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== rtl/rgbhsv_front.sv =====
// Front end of the converter: max/min and sector, then delta and signed
// difference, then hue numerator, divisors and saturation numerator.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  rgbhsv_pkg::pixel_t      pixel_i,
  output logic                    valid_o,
  output rgbhsv_pkg::div_stage_t  stage_o
);
  import rgbhsv_pkg::*;

  // stage 1: max, min, sector
  logic                s1_vld_q;
  logic [CompBits-1:0] s1_r_q, s1_g_q, s1_b_q, s1_mx_q, s1_mn_q;
  sector_e             s1_sec_q;
  logic [CompBits-1:0] s1_mx_d, s1_mn_d;
  sector_e             s1_sec_d;

  always_comb begin
    s1_mx_d = pixel_i.red_in;
    s1_mn_d = pixel_i.red_in;
    if (pixel_i.green_in > s1_mx_d) s1_mx_d = pixel_i.green_in;
    if (pixel_i.blue_in  > s1_mx_d) s1_mx_d = pixel_i.blue_in;
    if (pixel_i.green_in < s1_mn_d) s1_mn_d = pixel_i.green_in;
    if (pixel_i.blue_in  < s1_mn_d) s1_mn_d = pixel_i.blue_in;
    // red wins ties, then green
    if (pixel_i.red_in >= pixel_i.green_in && pixel_i.red_in >= pixel_i.blue_in) begin
      s1_sec_d = SecRed;
    end else if (pixel_i.green_in >= pixel_i.blue_in) begin
      s1_sec_d = SecGreen;
    end else begin
      s1_sec_d = SecBlue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_r_q   <= pixel_i.red_in;
    s1_g_q   <= pixel_i.green_in;
    s1_b_q   <= pixel_i.blue_in;
    s1_mx_q  <= s1_mx_d;
    s1_mn_q  <= s1_mn_d;
    s1_sec_q <= s1_sec_d;
  end

  // stage 2: delta and signed difference of the other two components
  logic                       s2_vld_q;
  logic [CompBits-1:0]        s2_mx_q, s2_dl_q;
  logic signed [CompBits:0]   s2_diff_q;
  sector_e                    s2_sec_q;
  logic                       s2_gray_q;
  logic signed [CompBits:0]   s2_diff_d;

  always_comb begin
    case (s1_sec_q)
      SecRed:   s2_diff_d = $signed({1'b0, s1_g_q}) - $signed({1'b0, s1_b_q});
      SecGreen: s2_diff_d = $signed({1'b0, s1_b_q}) - $signed({1'b0, s1_r_q});
      SecBlue:  s2_diff_d = $signed({1'b0, s1_r_q}) - $signed({1'b0, s1_g_q});
      default:  s2_diff_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mx_q   <= s1_mx_q;
    s2_dl_q   <= s1_mx_q - s1_mn_q;
    s2_diff_q <= s2_diff_d;
    s2_sec_q  <= s1_sec_q;
    s2_gray_q <= (s1_mx_q == s1_mn_q);
  end

  // stage 3: hue numerator in sixths of a turn, wrapped; divisors; saturation numerator
  logic                       s3_vld_q;
  div_stage_t                 s3_q;
  logic [HueDivW-1:0]         dl_x, base, six_d;
  logic signed [HueDivW:0]    num;
  logic [HueDivW-1:0]         num_w;
  logic [2*CompBits-1:0]      satnum;
  div_stage_t                 s3_d;

  always_comb begin
    dl_x  = {3'b000, s2_dl_q};
    six_d = (dl_x << 2) + (dl_x << 1);
    case (s2_sec_q)
      SecRed:   base = '0;
      SecGreen: base = dl_x << 1;
      SecBlue:  base = dl_x << 2;
      default:  base = '0;
    endcase
    num = $signed({1'b0, base}) + $signed({{3{s2_diff_q[CompBits]}}, s2_diff_q});
    if (num < 0) begin
      num = num + $signed({1'b0, six_d});
    end
    num_w  = num[HueDivW-1:0];
    satnum = {s2_dl_q, {CompBits{1'b0}}} - {{CompBits{1'b0}}, s2_dl_q};

    s3_d.gray = s2_gray_q;
    s3_d.val  = s2_mx_q;
    s3_d.hrem = num_w;
    s3_d.hdiv = six_d;
    s3_d.hq   = '0;
    s3_d.srem = satnum[2*CompBits-1:CompBits];
    s3_d.slo  = satnum[CompBits-1:0];
    s3_d.sq   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  assign valid_o = s3_vld_q;
  assign stage_o = s3_q;

endmodule

// ===== rtl/rgbhsv_div.sv =====
// Pipelined restoring divider: two hue quotient bits and one saturation
// quotient bit per stage, one register stage each. Depends on rgbhsv_pkg.
module rgbhsv_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  rgbhsv_pkg::div_stage_t  stage_i,
  output logic                    valid_o,
  output rgbhsv_pkg::div_stage_t  stage_o
);
  import rgbhsv_pkg::*;

  function automatic div_stage_t div_step(input div_stage_t cur, input int unsigned stg);
    div_stage_t          nxt;
    logic [HueDivW:0]    ht;
    logic [CompBits:0]   st;
    nxt = cur;
    for (int t = 0; t < HueStepsPerStage; t++) begin
      if (stg * HueStepsPerStage + t < HueBits) begin
        ht = {nxt.hrem, 1'b0};
        if (ht >= {1'b0, nxt.hdiv}) begin
          nxt.hrem = HueDivW'(ht - {1'b0, nxt.hdiv});
          nxt.hq   = {nxt.hq[HueBits-2:0], 1'b1};
        end else begin
          nxt.hrem = ht[HueDivW-1:0];
          nxt.hq   = {nxt.hq[HueBits-2:0], 1'b0};
        end
      end
    end
    if (stg < CompBits) begin
      st      = {nxt.srem, nxt.slo[CompBits-1]};
      nxt.slo = {nxt.slo[CompBits-2:0], 1'b0};
      if (st >= {1'b0, cur.val}) begin
        nxt.srem = CompBits'(st - {1'b0, cur.val});
        nxt.sq   = {nxt.sq[CompBits-2:0], 1'b1};
      end else begin
        nxt.srem = st[CompBits-1:0];
        nxt.sq   = {nxt.sq[CompBits-2:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  div_stage_t                stg_q [NumDivStages];
  logic [NumDivStages-1:0]   vld_q;

  for (genvar s = 0; s < NumDivStages; s++) begin : g_stage
    div_stage_t prev;
    logic       prev_vld;

    if (s == 0) begin : g_first
      assign prev     = stage_i;
      assign prev_vld = valid_i;
    end else begin : g_next
      assign prev     = stg_q[s-1];
      assign prev_vld = vld_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[s] <= div_step(prev, s);
    end
  end

  assign valid_o = vld_q[NumDivStages-1];
  assign stage_o = stg_q[NumDivStages-1];

endmodule

// ===== rtl/rgbhsv_checker.sv =====
// Port-level checker for rgb_to_hsv_converter, bound to the top level.
// Depends on rgbhsv_pkg.
module rgbhsv_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  rgbhsv_pkg::pixel_t  pixel_i,
  input  logic                busy,
  input  logic                done_o,
  input  rgbhsv_pkg::hsv_t    result_o
);
  import rgbhsv_pkg::*;

  logic [Latency-1:0] hist_q;

  function automatic logic [CompBits-1:0] max3(input pixel_t p);
    logic [CompBits-1:0] m;
    m = p.red_in;
    if (p.green_in > m) m = p.green_in;
    if (p.blue_in > m) m = p.blue_in;
    return m;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= {hist_q[Latency-2:0], start & ~busy};
    end
  end

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == hist_q[Latency-1])
    else $error("result strobe does not match request latency");

  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.sat_out == '0 |-> result_o.hue_out == '0)
    else $error("zero saturation with nonzero hue");

  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.val_out == max3($past(pixel_i, Latency)))
    else $error("value is not the largest component");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_checker (.*);

// ===== bench/rgb_to_hsv_converter_test.sv =====
// Self-checking bench for rgb_to_hsv_converter: directed corner pixels, then
// random bursts. Depends on rgbhsv_pkg and the converter RTL only.
`timescale 1ns / 100ps

module rgb_to_hsv_converter_test;
  import rgbhsv_pkg::*;

  // Max component value, the saturation full scale.
  localparam int FullScale = (1 << CompBits) - 1;
  localparam int NumRandom = 1050;

  // Clock, reset and DUT ports
  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   start;
  pixel_t pixel_i;
  logic   busy;
  logic   done_o;
  hsv_t   result_o;

  always #5 clk_i = ~clk_i;

  rgb_to_hsv_converter DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .pixel_i  (pixel_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Scoreboard: predicts HSV for each accepted request and checks results
  // in order. The converter keeps no state between pixels, so the
  // prediction depends on the request alone.
  class hsv_scoreboard;
    hsv_t pending_hsv[$];
    int   n_errors;
    int   n_checked;
    int   n_gray;
    int   n_sector[3];

    // Exact integer HSV. Red wins ties for the largest component, then green.
    function hsv_t predict_hsv(input pixel_t p, output sector_e sec);
      logic [CompBits-1:0] mx, mn, delta;
      longint              num;
      hsv_t                res;
      mx = p.red_in;
      mn = p.red_in;
      if (p.green_in > mx) mx = p.green_in;
      if (p.blue_in > mx) mx = p.blue_in;
      if (p.green_in < mn) mn = p.green_in;
      if (p.blue_in < mn) mn = p.blue_in;
      delta = mx - mn;
      res = '0;
      res.val_out = mx;
      sec = SecRed;
      if (delta != 0) begin
        res.sat_out = CompBits'((longint'(delta) * FullScale) / longint'(mx));
        if (p.red_in == mx) begin
          sec = SecRed;
          num = longint'(p.green_in) - longint'(p.blue_in);
        end else if (p.green_in == mx) begin
          sec = SecGreen;
          num = 2 * longint'(delta) + longint'(p.blue_in) - longint'(p.red_in);
        end else begin
          sec = SecBlue;
          num = 4 * longint'(delta) + longint'(p.red_in) - longint'(p.green_in);
        end
        // magenta side of red: wrap by one full turn
        if (num < 0) num += 6 * longint'(delta);
        res.hue_out = HueBits'((num <<< HueBits) / (6 * longint'(delta)));
      end
      return res;
    endfunction

    function void note_request(input pixel_t p);
      sector_e sec;
      hsv_t    want;
      want = predict_hsv(p, sec);
      pending_hsv.push_back(want);
      if (want.sat_out == 0 && p.red_in == p.green_in && p.green_in == p.blue_in)
        n_gray++;
      else
        n_sector[sec]++;
    endfunction

    function void check_result(input hsv_t got);
      hsv_t want;
      if (pending_hsv.size() == 0) begin
        $error("result with no request pending: hue %0d sat %0d val %0d",
               got.hue_out, got.sat_out, got.val_out);
        n_errors++;
        return;
      end
      want = pending_hsv.pop_front();
      n_checked++;
      if (got.hue_out !== want.hue_out) begin
        $error("hue_out: expected %0d, actual %0d", want.hue_out, got.hue_out);
        n_errors++;
      end
      if (got.sat_out !== want.sat_out) begin
        $error("sat_out: expected %0d, actual %0d", want.sat_out, got.sat_out);
        n_errors++;
      end
      if (got.val_out !== want.val_out) begin
        $error("val_out: expected %0d, actual %0d", want.val_out, got.val_out);
        n_errors++;
      end
    endfunction
  endclass

  hsv_scoreboard hsv_sb = new();

  // Result monitor. done_o and result_o are registered, so sampling at the
  // edge sees the cycle that the edge ends.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) hsv_sb.check_result(result_o);
  end

  // Drive one request and hold it until an edge sees start high, busy low.
  // start is left high so a following request goes out back to back.
  task automatic send_pixel(input pixel_t p);
    start   <= 1'b1;
    pixel_i <= p;
    do @(posedge clk_i); while (busy !== 1'b0);
    hsv_sb.note_request(p);
  endtask

  task automatic idle_cycles(input int n);
    start   <= 1'b0;
    pixel_i <= pixel_t'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  function automatic pixel_t make_pixel(input int r, input int g, input int b);
    pixel_t p;
    p.red_in   = CompBits'(r);
    p.green_in = CompBits'(g);
    p.blue_in  = CompBits'(b);
    return p;
  endfunction

  // Mostly uniform pixels; the rest are gray, pairs of equal components or tiny
  // spreads, where the sector choice and the divisions sit at their edges.
  function automatic pixel_t random_pixel();
    int     base, v;
    pixel_t p;
    p = pixel_t'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        v = $urandom_range(0, FullScale);
        p = make_pixel(v, v, v);
      end
      1: begin
        v = $urandom_range(0, FullScale);
        case ($urandom_range(0, 2))
          0: begin p.red_in = CompBits'(v); p.green_in = CompBits'(v); end
          1: begin p.green_in = CompBits'(v); p.blue_in = CompBits'(v); end
          default: begin p.red_in = CompBits'(v); p.blue_in = CompBits'(v); end
        endcase
      end
      2: begin
        base = $urandom_range(1, FullScale - 1);
        p = make_pixel(base + $urandom_range(0, 1) - $urandom_range(0, 1),
                       base + $urandom_range(0, 1) - $urandom_range(0, 1),
                       base + $urandom_range(0, 1) - $urandom_range(0, 1));
      end
      default: ;
    endcase
    return p;
  endfunction

  pixel_t directed_pixels[$];

  initial begin
    int burst_len;
    int n_sent;
    int guard;

    rst_ni  = 1'b0;
    start   = 1'b0;
    pixel_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: black, white, primaries, secondaries with ties between the
    // largest components, gray levels, one-step spreads, wrap of negative
    // hue just below a full turn, and alternating bit patterns.
    directed_pixels = '{
      make_pixel(0, 0, 0),       make_pixel(255, 255, 255),
      make_pixel(255, 0, 0),     make_pixel(0, 255, 0),
      make_pixel(0, 0, 255),     make_pixel(255, 255, 0),
      make_pixel(0, 255, 255),   make_pixel(255, 0, 255),
      make_pixel(128, 128, 128), make_pixel(1, 1, 1),
      make_pixel(255, 0, 1),     make_pixel(200, 10, 150),
      make_pixel(255, 254, 254), make_pixel(1, 0, 0),
      make_pixel(0, 1, 0),       make_pixel(0, 0, 1),
      make_pixel(170, 85, 0),    make_pixel(85, 170, 255),
      make_pixel(1, 255, 0),     make_pixel(254, 255, 255),
      make_pixel(100, 50, 100),  make_pixel(255, 1, 0)
    };
    foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
    idle_cycles(3);

    // Random bursts. Gap lengths vary so idle cycles land at every depth
    // of the pipeline; some bursts run straight into the next one.
    n_sent = 0;
    while (n_sent < NumRandom) begin
      burst_len = $urandom_range(1, 40);
      for (int k = 0; k < burst_len && n_sent < NumRandom; k++) begin
        send_pixel(random_pixel());
        n_sent++;
      end
      if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 2 * Latency));
    end
    idle_cycles(1);

    // Drain, then give the pipeline time to show any stray strobe.
    guard = 0;
    while (hsv_sb.pending_hsv.size() != 0 && guard < 100 * Latency) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 4) @(posedge clk_i);

    if (hsv_sb.pending_hsv.size() != 0) begin
      $error("%0d results never arrived", hsv_sb.pending_hsv.size());
      hsv_sb.n_errors++;
    end

    $display("Checked %0d pixels in bursts with random gaps", hsv_sb.n_checked);
    $display("Hue sectors red %0d, green %0d, blue %0d; gray %0d",
             hsv_sb.n_sector[SecRed], hsv_sb.n_sector[SecGreen],
             hsv_sb.n_sector[SecBlue], hsv_sb.n_gray);
    if (hsv_sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: ends the run as failed if it does not finish.
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
